/* rtl/sgpg_pkg.sv */
// ----------------------------------------------------------------------------
// sgpg_pkg
// Shared types and constants of the skip-gram pair generator.
// ----------------------------------------------------------------------------
package sgpg_pkg;

	localparam int MAX_WINDOW_DEF = 8;
	localparam int TOKEN_BITS_DEF = 32;

	localparam int ID_W     = 32;
	localparam int WIN_W    = 4;
	localparam int SHRINK_W = 3;
	localparam int FILL_W   = 5;

	localparam logic [WIN_W-1:0]  WINDOW_RESET = 4'd5;
	localparam logic [FILL_W-1:0] FILL_MAX     = 5'd31;

	localparam logic KIND_PUSH  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [ID_W-1:0]     token_id;
		logic                token_empty;
		logic                new_row;
		logic [SHRINK_W-1:0] window_shrink;
	} token_in_t;

	typedef struct packed {
		logic [ID_W-1:0] target_id;
		logic [ID_W-1:0] context_id;
		logic            last_pair;
	} pair_out_t;

	// sequencer to pair buffer
	typedef struct packed {
		logic pair_vld;
		logic close;
	} pb_ctrl_t;

	// pair buffer to sequencer
	typedef struct packed {
		logic ready;
		logic hold;
	} pb_stat_t;

endpackage

/* rtl/sgpg_ram.sv */
// ----------------------------------------------------------------------------
// sgpg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sgpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

/* rtl/sgpg_pair_buf.sv */
// ----------------------------------------------------------------------------
// sgpg_pair_buf
// Holds back one pair so the final pair of an item can be marked, and drives
// the output register of the pair channel.
// ----------------------------------------------------------------------------
module sgpg_pair_buf #(
	parameter int TB_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sgpg_pkg::pb_ctrl_t ctrl,
	input  logic [TB_W-1:0]    ctx,
	input  logic [TB_W-1:0]    tid,
	output sgpg_pkg::pb_stat_t stat,
	output logic               pair_valid,
	input  logic               pair_stall,
	output sgpg_pkg::pair_out_t pair
);

	logic                pair_valid_q;
	sgpg_pkg::pair_out_t pair_q;
	logic                hold_v_q;
	logic [TB_W-1:0]     hold_q;
	logic                load;

	// a new pair pushes the held one out; close pushes it out as the last one
	assign load = (ctrl.pair_vld && hold_v_q) || ctrl.close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
			hold_v_q     <= 1'b0;
		end else begin
			if (load) begin
				pair_valid_q <= 1'b1;
			end else if (!pair_stall) begin
				pair_valid_q <= 1'b0;
			end
			if (ctrl.pair_vld) begin
				hold_v_q <= 1'b1;
			end else if (ctrl.close) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_q.target_id  <= sgpg_pkg::ID_W'(tid);
			pair_q.context_id <= sgpg_pkg::ID_W'(hold_q);
			pair_q.last_pair  <= ctrl.close;
		end
		if (ctrl.pair_vld) begin
			hold_q <= ctx;
		end
	end

	assign stat.ready = !pair_valid_q || !pair_stall;
	assign stat.hold  = hold_v_q;
	assign pair_valid = pair_valid_q;
	assign pair       = pair_q;

endmodule

/* rtl/skip_gram_pair_generator.sv */
// ----------------------------------------------------------------------------
// skip_gram_pair_generator
// Takes one token or flush beat at a time and keeps the recent tokens of the
// row in a ring RAM of 2*MAX_WINDOW+1 entries. After each beat the oldest
// pending target is read back and, once its right context is known (or a
// flush ends the row), one (target, context) pair is sent per non-empty
// context in its window, oldest context first, the final pair flagged by
// last_pair. A new beat is taken only when the previous one is finished: a
// beat that completes a target walks the ring slots of its window, as the
// single read port of the ring RAM visits one ring slot per cycle while the
// pair channel does not stall.
// Window writes belong to idle periods.
// ----------------------------------------------------------------------------
module skip_gram_pair_generator #(
	parameter int MAX_WINDOW = sgpg_pkg::MAX_WINDOW_DEF,
	parameter int TOKEN_BITS = sgpg_pkg::TOKEN_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tok_valid,
	output logic                        tok_stall,
	input  sgpg_pkg::token_in_t         tok,
	output logic                        pair_valid,
	input  logic                        pair_stall,
	output sgpg_pkg::pair_out_t         pair,
	input  logic                        cfg_we,
	input  logic [sgpg_pkg::WIN_W-1:0]  cfg_wdata
);

	localparam int DEPTH = 2 * MAX_WINDOW + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(2 * MAX_WINDOW + 1);
	localparam int KW    = $clog2(3 * MAX_WINDOW);
	localparam int CW    = $clog2(4 * MAX_WINDOW + 33);
	localparam int TB_W  = (TOKEN_BITS < sgpg_pkg::ID_W) ? TOKEN_BITS : sgpg_pkg::ID_W;
	localparam int RW    = TB_W + 1 + sgpg_pkg::SHRINK_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TRD   = 3'd1;
	localparam logic [2:0] ST_TEVAL = 3'd2;
	localparam logic [2:0] ST_CTX   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]                    state_q;
	logic [sgpg_pkg::WIN_W-1:0]    window_q;
	logic [AW-1:0]                 head_q;
	logic [sgpg_pkg::FILL_W-1:0]   fill_q;
	logic [PW-1:0]                 pend_q;
	logic [DEPTH-1:0]              written_q;
	logic                          flush_q;
	logic [PW-1:0]                 d_q;
	logic [KW-1:0]                 k_q;
	logic [KW-1:0]                 kend_q;
	logic [TB_W-1:0]               tid_q;

	logic                          vb_s1;
	logic                          valid_s1;
	logic                          self_s1;

	logic                          tok_acc;
	logic                          push;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [RW-1:0]                 ram_wdata;
	logic [RW-1:0]                 ram_rdata;
	logic [TB_W-1:0]               rd_tok;
	logic                          rd_empty;
	logic [sgpg_pkg::SHRINK_W-1:0] rd_shrink;

	logic                          issue;
	logic                          consume;
	logic                          ne;
	sgpg_pkg::pb_ctrl_t            pb_ctrl;
	sgpg_pkg::pb_stat_t            pb_stat;

	logic [CW-1:0]                 w_eff;
	logic [CW-1:0]                 shr;
	logic [CW-1:0]                 h;
	logic [CW-1:0]                 dc;
	logic [CW-1:0]                 right;
	logic [CW-1:0]                 prior;
	logic [CW-1:0]                 left;
	logic                          t_empty;
	logic                          t_wait;

	// ring slot of the token k places behind the newest one
	function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] head,
			input logic [KW-1:0] k);
		logic [CW-1:0] km;
		logic [CW-1:0] s;
		km = CW'(k);
		if (km >= CW'(DEPTH)) begin
			km = km - CW'(DEPTH);
		end
		s = CW'(head) + CW'(DEPTH - 1) - km;
		if (s >= CW'(DEPTH)) begin
			s = s - CW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign tok_stall = (state_q != ST_IDLE);
	assign tok_acc   = tok_valid && !tok_stall;
	assign push      = tok_acc && (tok.kind == sgpg_pkg::KIND_PUSH);
	assign ram_wdata = {tok.token_id[TB_W-1:0], tok.token_empty, tok.window_shrink};

	assign rd_tok    = ram_rdata[RW-1 -: TB_W];
	assign rd_empty  = ram_rdata[sgpg_pkg::SHRINK_W];
	assign rd_shrink = ram_rdata[sgpg_pkg::SHRINK_W-1:0];

	// context pipeline: one read issued per cycle while the stage ahead moves
	assign consume = valid_s1 && pb_stat.ready;
	assign issue   = (state_q == ST_CTX) && (!valid_s1 || consume);
	// unwritten slots read as non-empty with zero shrink
	assign ne      = !self_s1 && !(vb_s1 && rd_empty);

	assign pb_ctrl.pair_vld = consume && ne;
	assign pb_ctrl.close    = (state_q == ST_DRAIN) && !valid_s1 && pb_stat.hold
		&& pb_stat.ready;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = slot_back(head_q, k_q);
		if (state_q == ST_TRD) begin
			ram_re    = (pend_q != '0);
			ram_raddr = slot_back(head_q, KW'(pend_q - 1'b1));
		end else if (issue) begin
			ram_re = 1'b1;
		end
	end

	// target evaluation on the read-back entry
	always_comb begin
		w_eff = CW'(window_q);
		if (w_eff == '0) begin
			w_eff = CW'(1);
		end else if (w_eff > CW'(MAX_WINDOW)) begin
			w_eff = CW'(MAX_WINDOW);
		end
		shr = vb_s1 ? CW'(rd_shrink) : '0;
		if (shr >= w_eff) begin
			shr = w_eff - CW'(1);
		end
		h       = w_eff - shr;
		dc      = CW'(d_q);
		t_empty = vb_s1 && rd_empty;
		t_wait  = !flush_q && (dc < h);
		right   = (dc < h) ? dc : h;
		prior   = (CW'(fill_q) > dc) ? (CW'(fill_q) - CW'(1) - dc) : '0;
		left    = (prior < h) ? prior : h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			window_q  <= sgpg_pkg::WINDOW_RESET;
			head_q    <= '0;
			fill_q    <= '0;
			pend_q    <= '0;
			written_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tok_acc) begin
						state_q <= ST_TRD;
					end
					if (push) begin
						written_q[head_q] <= 1'b1;
						head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
						if (tok.new_row) begin
							fill_q <= sgpg_pkg::FILL_W'(1);
							pend_q <= PW'(1);
						end else begin
							if (fill_q < sgpg_pkg::FILL_MAX) begin
								fill_q <= fill_q + 1'b1;
							end
							if (pend_q < PW'(2 * MAX_WINDOW)) begin
								pend_q <= pend_q + 1'b1;
							end
						end
					end
				end
				ST_TRD: begin
					state_q <= (pend_q == '0) ? ST_IDLE : ST_TEVAL;
				end
				ST_TEVAL: begin
					if (t_empty) begin
						pend_q  <= pend_q - 1'b1;
						state_q <= ST_IDLE;
					end else if (t_wait) begin
						state_q <= ST_IDLE;
					end else begin
						pend_q  <= pend_q - 1'b1;
						state_q <= ST_CTX;
					end
				end
				ST_CTX: begin
					if (issue && (k_q == kend_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && (!pb_stat.hold || pb_stat.ready)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tok_acc) begin
			flush_q <= (tok.kind == sgpg_pkg::KIND_FLUSH);
		end
		if (state_q == ST_TRD) begin
			d_q <= pend_q - 1'b1;
		end
		if (ram_re) begin
			vb_s1 <= written_q[ram_raddr];
		end
		if (issue) begin
			self_s1 <= (k_q == KW'(d_q));
			if (k_q != kend_q) begin
				k_q <= k_q - 1'b1;
			end
		end else if (state_q == ST_TEVAL) begin
			k_q    <= KW'(dc + left);
			kend_q <= KW'(dc - right);
			tid_q  <= rd_tok;
		end
	end

	sgpg_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (head_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sgpg_pair_buf #(
		.TB_W (TB_W)
	) u_pair_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (pb_ctrl),
		.ctx        (rd_tok),
		.tid        (tid_q),
		.stat       (pb_stat),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair)
	);

`ifndef SYNTH
	a_push_reads_target: assert property (@(posedge clk) disable iff (!arst_n)
		tok_acc |=> (state_q == ST_TRD))
		else $error("accepted beat not followed by target read");

	a_ctx_stage_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((state_q == ST_CTX) || (state_q == ST_DRAIN)))
		else $error("context stage busy outside the window walk");

	a_no_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pb_stat.hold)
		else $error("pair held back while idle");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEVAL) |-> (pend_q != '0))
		else $error("target evaluated with no pending target");
`endif

endmodule
